>>> src/esp_pkg.sv
// esp_pkg: shared widths, constants, payload and command types for the
// encoder angle and speed estimator. No dependencies.
`timescale 1ns / 1ps
package esp_pkg;

  // field widths
  localparam int RAW_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CPR_W   = 24;
  localparam int PP_W    = 7;
  localparam int ANG_W   = 16;
  localparam int SPD_W   = 24;
  localparam int IDX_W   = 2;

  // angle resolution in bits (at most ANG_W, the output angle width)
  localparam int ANGLE_BITS = 16;

  // microseconds per minute and its width
  localparam int MIN_W = 26;
  localparam logic [MIN_W-1:0] US_PER_MIN = MIN_W'(60000000);

  // speed numerator, divisor and shared datapath widths
  localparam int NUM_W = RAW_W + MIN_W - 1;
  localparam int DEN_W = CPR_W + TIME_W;
  localparam int POS_W = CPR_W + PP_W;
  localparam int DW    = NUM_W + 1;
  localparam int CW    = $clog2(DW);

  // register indexes
  localparam logic [IDX_W-1:0] REG_CPR = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PP  = IDX_W'(1);

  // register reset values
  localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);
  localparam logic [PP_W-1:0]  PP_RESET  = PP_W'(4);

  typedef struct packed {
    logic [RAW_W-1:0]  raw_count;
    logic [TIME_W-1:0] time_us;
  } esp_in_t;

  typedef struct packed {
    logic [ANG_W-1:0]        elec_angle;
    logic signed [SPD_W-1:0] speed_rpm;
    logic                    speed_fresh;
  } esp_out_t;

  // one job for the serial unit
  typedef struct packed {
    logic          load;
    logic          mul;
    logic [CW-1:0] steps;
    logic [DW-1:0] r_init;
    logic [DW-1:0] d_init;
    logic [DW-1:0] v_init;
  } esp_cmd_t;

endpackage

>>> src/esp_serial_unit.sv
// esp_serial_unit: shared shift-add multiplier and restoring divider, one
// bit per cycle on a single adder. Depends on esp_pkg.
`timescale 1ns / 1ps
module esp_serial_unit import esp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  esp_cmd_t      cmd,
  output logic          done,
  output logic [DW-1:0] res_r,
  output logic [DW-1:0] res_d
);

  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW-1:0] v_r, v_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          mul_r, mul_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW-1:0] r_shift;
  logic [DW-1:0] add_a;
  logic [DW:0]   add_b;
  logic [DW:0]   add_res;

  // one adder: r + v when multiplying, shifted r - v when dividing
  assign r_shift = {r_r[DW-2:0], d_r[DW-1]};
  assign add_a   = mul_r ? r_r : r_shift;
  assign add_b   = mul_r ? {1'b0, v_r} : ~{1'b0, v_r};
  assign add_res = {1'b0, add_a} + add_b + (DW+1)'(!mul_r);

  // step and load
  always_comb begin
    r_nxt    = r_r;
    d_nxt    = d_r;
    v_nxt    = v_r;
    cnt_nxt  = cnt_r;
    mul_nxt  = mul_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.load) begin
      r_nxt    = cmd.r_init;
      d_nxt    = cmd.d_init;
      v_nxt    = cmd.v_init;
      cnt_nxt  = cmd.steps;
      mul_nxt  = cmd.mul;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mul_r) begin
        r_nxt = d_r[0] ? add_res[DW-1:0] : r_r;
        d_nxt = d_r >> 1;
        v_nxt = v_r << 1;
      end else begin
        r_nxt = add_res[DW] ? r_shift : add_res[DW-1:0];
        d_nxt = {d_r[DW-2:0], !add_res[DW]};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    v_r   <= v_nxt;
    cnt_r <= cnt_nxt;
    mul_r <= mul_nxt;
  end

  assign done  = done_r;
  assign res_r = r_r;
  assign res_d = d_r;

endmodule

>>> src/encoder_angle_speed_estimator_top.sv
// Encoder angle and speed estimator: one result per reading, all arithmetic
// on one shared serial unit (esp_serial_unit, one bit per cycle).
// Each reading runs through the sequencer states in turn; the speed steps are
// skipped and the held speed is output when the reading is not fresh.
// in_stall holds off the next reading until this result is loaded out.
// Synchronous active-low reset: 4096 counts per rev, 4 pole pairs, state zero.
`timescale 1ns / 1ps
module encoder_angle_speed_estimator_top import esp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  esp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output esp_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CPR_W-1:0] cfg_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RMOD = 4'd1;
  localparam logic [3:0] ST_PMUL = 4'd2;
  localparam logic [3:0] ST_PMOD = 4'd3;
  localparam logic [3:0] ST_ADIV = 4'd4;
  localparam logic [3:0] ST_SDEN = 4'd5;
  localparam logic [3:0] ST_SNUM = 4'd6;
  localparam logic [3:0] ST_SDIV = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [NUM_W-1:0] SAT_POS = NUM_W'((1 << (SPD_W - 1)) - 1);
  localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(1 << (SPD_W - 1));

  logic [3:0]              state_r, state_nxt;
  logic [CPR_W-1:0]        cpr_r;
  logic [PP_W-1:0]         pp_r;
  logic [RAW_W-1:0]        prev_count_r;
  logic [TIME_W-1:0]       prev_time_r;
  logic signed [SPD_W-1:0] held_speed_r;
  logic [TIME_W-1:0]       dt_r;
  logic [RAW_W-1:0]        mag_r;
  logic                    neg_r;
  logic                    fresh_r;
  logic [DEN_W-1:0]        den_r;
  logic [ANG_W-1:0]        angle_r;
  logic                    out_valid_r;
  esp_out_t                out_data_r;

  logic                    in_acc;
  logic                    out_load;
  logic [CPR_W-1:0]        eff_cpr;
  logic [RAW_W-1:0]        diff;
  logic [NUM_W-1:0]        quot;
  logic signed [SPD_W-1:0] speed_sat;

  esp_cmd_t                cmd;
  logic                    unit_done;
  logic [DW-1:0]           unit_r;
  logic [DW-1:0]           unit_d;

  esp_serial_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .done  (unit_done),
    .res_r (unit_r),
    .res_d (unit_d)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign eff_cpr   = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
  assign diff      = in_data.raw_count - prev_count_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // saturate the unsigned quotient with the sign of the count difference
  assign quot = unit_d[NUM_W-1:0];
  always_comb begin
    if (neg_r) begin
      speed_sat = (quot > SAT_NEG) ? -SPD_W'(signed'(SAT_NEG[SPD_W-1:0]))
                                   : -signed'(quot[SPD_W-1:0]);
    end else begin
      speed_sat = (quot > SAT_POS) ? signed'(SAT_POS[SPD_W-1:0])
                                   : signed'(quot[SPD_W-1:0]);
    end
  end

  // sequencer: issue the next job to the serial unit as each one finishes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load   = 1'b1;
          cmd.steps  = CW'(RAW_W);
          cmd.d_init = {in_data.raw_count, {(DW-RAW_W){1'b0}}};
          cmd.v_init = DW'(eff_cpr);
          state_nxt  = ST_RMOD;
        end
      end
      ST_RMOD: begin
        if (unit_done) begin
          cmd.load   = 1'b1;
          cmd.mul    = 1'b1;
          cmd.steps  = CW'(PP_W);
          cmd.d_init = DW'(pp_r);
          cmd.v_init = DW'(unit_r[CPR_W-1:0]);
          state_nxt  = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (unit_done) begin
          cmd.load   = 1'b1;
          cmd.steps  = CW'(POS_W);
          cmd.d_init = {unit_r[POS_W-1:0], {(DW-POS_W){1'b0}}};
          cmd.v_init = DW'(eff_cpr);
          state_nxt  = ST_PMOD;
        end
      end
      ST_PMOD: begin
        if (unit_done) begin
          cmd.load   = 1'b1;
          cmd.steps  = CW'(ANGLE_BITS);
          cmd.r_init = DW'(unit_r[CPR_W-1:0]);
          cmd.v_init = DW'(eff_cpr);
          state_nxt  = ST_ADIV;
        end
      end
      ST_ADIV: begin
        if (unit_done) begin
          if (fresh_r) begin
            cmd.load   = 1'b1;
            cmd.mul    = 1'b1;
            cmd.steps  = CW'(CPR_W);
            cmd.d_init = DW'(eff_cpr);
            cmd.v_init = DW'(dt_r);
            state_nxt  = ST_SDEN;
          end else begin
            state_nxt  = ST_OUT;
          end
        end
      end
      ST_SDEN: begin
        if (unit_done) begin
          cmd.load   = 1'b1;
          cmd.mul    = 1'b1;
          cmd.steps  = CW'(MIN_W);
          cmd.d_init = DW'(US_PER_MIN);
          cmd.v_init = DW'(mag_r);
          state_nxt  = ST_SNUM;
        end
      end
      ST_SNUM: begin
        if (unit_done) begin
          cmd.load   = 1'b1;
          cmd.steps  = CW'(NUM_W);
          cmd.d_init = {unit_r[NUM_W-1:0], 1'b0};
          cmd.v_init = DW'(den_r);
          state_nxt  = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (unit_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, registers and stored reading
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cpr_r        <= CPR_RESET;
      pp_r         <= PP_RESET;
      prev_count_r <= '0;
      prev_time_r  <= '0;
      held_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CPR) begin
          cpr_r <= cfg_data;
        end else if (cfg_index == REG_PP) begin
          pp_r <= cfg_data[PP_W-1:0];
        end
      end
      if (in_acc) begin
        prev_count_r <= in_data.raw_count;
        prev_time_r  <= in_data.time_us;
      end
      if ((state_r == ST_SDIV) && unit_done) begin
        held_speed_r <= speed_sat;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-transaction working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r   <= diff[RAW_W-1];
      mag_r   <= diff[RAW_W-1] ? (RAW_W'(0) - diff) : diff;
      dt_r    <= in_data.time_us - prev_time_r;
      fresh_r <= (prev_time_r != '0) && (in_data.time_us > prev_time_r);
    end
    if ((state_r == ST_ADIV) && unit_done) begin
      angle_r <= unit_d[ANG_W-1:0];
    end
    if ((state_r == ST_SDEN) && unit_done) begin
      den_r <= unit_r[DEN_W-1:0];
    end
    if (out_load) begin
      out_data_r.elec_angle  <= angle_r;
      out_data_r.speed_rpm   <= held_speed_r;
      out_data_r.speed_fresh <= fresh_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
